/* src/fsrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency sweep RSSI sequencer package
// Shared codes, register indexes and default sizes for the sweep sequencer.
// ----------------------------------------------------------------------------
package fsrs_pkg;

  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_SAMPLE_BITS = 12;
  localparam int DEF_FREQ_BITS   = 23;

  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;
  localparam int EV_W      = 3;
  localparam int ERR_W     = 2;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [EV_W-1:0]      event_t;
  typedef logic [ERR_W-1:0]     err_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           conv_t;
  typedef logic [1:0]           phase_t;

  localparam op_t OP_START  = 2'd0;
  localparam op_t OP_TICK   = 2'd1;
  localparam op_t OP_SAMPLE = 2'd2;
  localparam op_t OP_DONE   = 2'd3;

  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_RETUNE   = 3'd1;
  localparam event_t EV_TRIGGER  = 3'd2;
  localparam event_t EV_RSSI     = 3'd3;
  localparam event_t EV_ACCEPTED = 3'd4;
  localparam event_t EV_REJECTED = 3'd5;

  localparam err_t ERR_NONE       = 2'd0;
  localparam err_t ERR_START_BAND = 2'd1;
  localparam err_t ERR_STOP_BAND  = 2'd2;
  localparam err_t ERR_ORDER      = 2'd3;

  localparam conv_t CONV_IDLE     = 2'd0;
  localparam conv_t CONV_SAMPLING = 2'd1;
  localparam conv_t CONV_DONE     = 2'd2;

  localparam phase_t PHASE_RETUNE  = 2'd0;
  localparam phase_t PHASE_TRIGGER = 2'd1;
  localparam phase_t PHASE_REPORT  = 2'd2;

  localparam cfg_idx_t CFG_SWEEP_START = 3'd0;
  localparam cfg_idx_t CFG_SWEEP_STOP  = 3'd1;
  localparam cfg_idx_t CFG_SWEEP_STEP  = 3'd2;
  localparam cfg_idx_t CFG_BAND_LOW    = 3'd3;
  localparam cfg_idx_t CFG_BAND_HIGH   = 3'd4;
  localparam cfg_idx_t CFG_IF_OFFSET   = 3'd5;

endpackage

/* src/frequency_sweep_rssi_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency sweep RSSI sequencer
// Steps a receiver frequency between configured limits, triggers the
// converter, accumulates samples and reports the averaged RSSI.
// ----------------------------------------------------------------------------
// A result passes through the execute state and, for an RSSI report with samples,
// through the bit-serial divider (one quotient bit a cycle over SAMPLE_BITS +
// clog2(MAX_SAMPLES + 1) bits), then is registered at the output once it is free.
// A request is taken only when idle, not before the previous result leaves the done state.
// A new request is taken while the previous result still waits at the output.
// Synchronous reset clears the sweep state and loads register defaults.
module frequency_sweep_rssi_sequencer #(
  parameter int MAX_SAMPLES = fsrs_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = fsrs_pkg::DEF_SAMPLE_BITS,
  parameter int FREQ_BITS   = fsrs_pkg::DEF_FREQ_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  fsrs_pkg::cfg_idx_t             cfg_index,
  input  logic [FREQ_BITS-1:0]           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fsrs_pkg::op_t                  operation,
  input  logic [SAMPLE_BITS-1:0]         sample_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fsrs_pkg::event_t               event_res,
  output fsrs_pkg::err_t                 error_kind,
  output logic signed [FREQ_BITS:0]      synth_freq_khz,
  output logic [FREQ_BITS-1:0]           sweep_freq_khz,
  output logic [SAMPLE_BITS-1:0]         rssi_level,
  output logic                           sweep_started,
  output logic                           sweep_stopped
);
  import fsrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int DIV_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [FREQ_BITS-1:0] sweep_start, sweep_stop, sweep_step;
  logic [FREQ_BITS-1:0] band_low, band_high, if_offset;

  logic [1:0]             state;
  logic                   sweep_running;
  phase_t                 sweep_phase;
  logic [FREQ_BITS-1:0]   current_point;
  logic                   first_step;
  conv_t                  converter_status;
  logic [SUM_W-1:0]       sample_sum;
  logic [CNT_W-1:0]       sample_count;

  op_t                    req_op;
  logic [SAMPLE_BITS-1:0] req_sample;

  event_t                 res_ev;
  err_t                   res_err;
  logic [FREQ_BITS-1:0]   res_freq;
  logic                   res_started;
  logic                   res_stopped;

  logic [SUM_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       divisor;
  logic [DIV_W-1:0]       div_cnt;

  logic                   start_bad, stop_bad, order_bad;
  logic [FREQ_BITS:0]     next_sum;
  logic                   next_past_stop;
  logic [CNT_W:0]         rem_shift;
  logic [CNT_W+1:0]       trial;
  logic                   trial_ge;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  assign start_bad = (sweep_start < band_low) || (sweep_start > band_high);
  assign stop_bad  = (sweep_stop < band_low) || (sweep_stop > band_high);
  assign order_bad = (sweep_start > sweep_stop);

  assign next_sum       = {1'b0, current_point} + {1'b0, sweep_step};
  assign next_past_stop = (next_sum > {1'b0, sweep_stop});

  assign rem_shift = {rem, quo[SUM_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, divisor};
  assign trial_ge  = !trial[CNT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_start <= '0;
      sweep_stop  <= '0;
      sweep_step  <= '0;
      band_low    <= '0;
      band_high   <= '1;
      if_offset   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SWEEP_START: sweep_start <= cfg_data;
        CFG_SWEEP_STOP:  sweep_stop  <= cfg_data;
        CFG_SWEEP_STEP:  sweep_step  <= cfg_data;
        CFG_BAND_LOW:    band_low    <= cfg_data;
        CFG_BAND_HIGH:   band_high   <= cfg_data;
        CFG_IF_OFFSET:   if_offset   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op     <= operation;
      req_sample <= sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      sweep_running    <= 1'b0;
      sweep_phase      <= PHASE_RETUNE;
      current_point    <= '0;
      first_step       <= 1'b1;
      converter_status <= CONV_IDLE;
      sample_sum       <= '0;
      sample_count     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_ev      <= EV_NONE;
          res_err     <= ERR_NONE;
          res_freq    <= '0;
          res_started <= 1'b0;
          res_stopped <= 1'b0;
          quo         <= '0;
          state       <= ST_DONE;
          unique case (req_op)
            OP_START: begin
              if (start_bad) begin
                res_ev  <= EV_REJECTED;
                res_err <= ERR_START_BAND;
              end else if (stop_bad) begin
                res_ev  <= EV_REJECTED;
                res_err <= ERR_STOP_BAND;
              end else if (order_bad) begin
                res_ev  <= EV_REJECTED;
                res_err <= ERR_ORDER;
              end else begin
                res_ev        <= EV_ACCEPTED;
                current_point <= '0;
                first_step    <= 1'b1;
                sweep_phase   <= PHASE_RETUNE;
                sweep_running <= 1'b1;
              end
            end
            OP_TICK: begin
              if (sweep_running) begin
                unique case (sweep_phase)
                  PHASE_RETUNE: begin
                    res_ev      <= EV_RETUNE;
                    sweep_phase <= PHASE_TRIGGER;
                    if (first_step) begin
                      current_point <= sweep_start;
                      res_freq      <= sweep_start;
                      first_step    <= 1'b0;
                      res_started   <= 1'b1;
                    end else if (next_past_stop) begin
                      current_point <= sweep_start;
                      res_freq      <= sweep_start;
                    end else begin
                      current_point <= next_sum[FREQ_BITS-1:0];
                      res_freq      <= next_sum[FREQ_BITS-1:0];
                    end
                  end
                  PHASE_TRIGGER: begin
                    if (converter_status == CONV_IDLE) begin
                      converter_status <= CONV_SAMPLING;
                      sweep_phase      <= PHASE_REPORT;
                      res_ev           <= EV_TRIGGER;
                    end
                  end
                  PHASE_REPORT: begin
                    if (converter_status == CONV_DONE) begin
                      res_ev           <= EV_RSSI;
                      res_freq         <= current_point;
                      sample_sum       <= '0;
                      sample_count     <= '0;
                      converter_status <= CONV_IDLE;
                      sweep_phase      <= PHASE_RETUNE;
                      if (next_past_stop) begin
                        sweep_running <= 1'b0;
                        res_stopped   <= 1'b1;
                      end
                      if (sample_count != '0) begin
                        quo     <= sample_sum;
                        rem     <= '0;
                        divisor <= sample_count;
                        div_cnt <= DIV_W'(SUM_W - 1);
                        state   <= ST_DIV;
                      end
                    end
                  end
                  default: begin
                    sweep_phase <= PHASE_RETUNE;
                  end
                endcase
              end
            end
            OP_SAMPLE: begin
              if ((converter_status == CONV_SAMPLING) &&
                  (sample_count < CNT_W'(MAX_SAMPLES))) begin
                sample_sum   <= sample_sum + SUM_W'(req_sample);
                sample_count <= sample_count + CNT_W'(1);
              end
            end
            default: begin
              if (converter_status == CONV_SAMPLING) begin
                converter_status <= CONV_DONE;
              end
            end
          endcase
        end
        ST_DIV: begin
          rem     <= trial_ge ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
          quo     <= {quo[SUM_W-2:0], trial_ge};
          div_cnt <= div_cnt - DIV_W'(1);
          if (div_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        default: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            event_res      <= res_ev;
            error_kind     <= res_err;
            sweep_freq_khz <= res_freq;
            rssi_level     <= quo[SAMPLE_BITS-1:0];
            sweep_started  <= res_started;
            sweep_stopped  <= res_stopped;
            synth_freq_khz <= (res_ev == EV_RETUNE) ?
                              ({1'b0, res_freq} - {1'b0, if_offset}) : '0;
            state          <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("Sample count exceeds its limit.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_EXEC)
    else $error("Accepted request did not enter execution.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(rssi_level))
    else $error("Stalled result changed.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && sweep_stopped |-> event_res == EV_RSSI)
    else $error("Sweep end flagged outside an RSSI report.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && sweep_started |-> event_res == EV_RETUNE)
    else $error("Sweep start flagged outside a retune.");

endmodule
